@@ src/cct_pkg.sv @@
`default_nettype none

package cct_pkg;

    localparam int SEC_W   = 6;
    localparam int MIN_W   = 6;
    localparam int HOUR_W  = 5;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int IDLE_W  = 8;

    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    localparam logic [SEC_W-1:0]   SEC_LAST   = 6'd59;
    localparam logic [MIN_W-1:0]   MIN_LAST   = 6'd59;
    localparam logic [HOUR_W-1:0]  HOUR_LAST  = 5'd23;
    localparam logic [MONTH_W-1:0] MONTH_LAST = 4'd12;
    localparam logic [YEAR_W-1:0]  YEAR_CAP   = 14'd9999;
    localparam logic [IDLE_W-1:0]  IDLE_MAX   = 8'd255;
    localparam logic [IDLE_W-1:0]  IDLE_LIMIT_RST = 8'd4;

    localparam logic [DAY_W-1:0]   DAY_RST   = 5'd1;
    localparam logic [MONTH_W-1:0] MONTH_RST = 4'd1;
    localparam logic [YEAR_W-1:0]  YEAR_RST  = 14'd2000;

    localparam logic [DAY_W-1:0] LEN_FEB_LEAP = 5'd29;
    localparam logic [DAY_W-1:0] LEN_FEB      = 5'd28;
    localparam logic [DAY_W-1:0] LEN_LONG     = 5'd31;
    localparam logic [DAY_W-1:0] LEN_SHORT    = 5'd30;

    // odd divisor test: y*inv(25) mod 2^14 is small exactly when 25 divides y
    localparam logic [YEAR_W-1:0] YEAR_INV25     = 14'd7209;
    localparam logic [YEAR_W-1:0] YEAR_DIV25_MAX = 14'd655;

    typedef struct packed {
        logic               command;
        logic [SEC_W-1:0]   load_second;
        logic [MIN_W-1:0]   load_minute;
        logic [HOUR_W-1:0]  load_hour;
        logic [DAY_W-1:0]   load_day;
        logic [MONTH_W-1:0] load_month;
        logic [YEAR_W-1:0]  load_year;
        logic               keys_idle;
    } t_item;

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
        logic               backlight_on;
        logic               day_rollover;
    } t_result;

    function automatic logic f_is_leap(input logic [YEAR_W-1:0] y);
        logic [YEAR_W-1:0] prod;
        logic              div25;
        prod  = YEAR_W'(y * YEAR_INV25);
        div25 = (prod <= YEAR_DIV25_MAX);
        // divisible by 4 but not 100, or by 16 and 25 (that is, by 400)
        return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
    endfunction

    function automatic logic [DAY_W-1:0] f_month_len(input logic [MONTH_W-1:0] m,
                                                     input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd2:    len = leap ? LEN_FEB_LEAP : LEN_FEB;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = LEN_LONG;
            default: len = LEN_SHORT;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

@@ src/cct_in_stage.sv @@
`default_nettype none

module cct_in_stage (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_valid,
    output logic           o_ready,
    input  cct_pkg::t_item i_item,
    output logic           o_valid,
    output cct_pkg::t_item o_item,
    input  wire            i_take
);

    logic           r_valid;
    cct_pkg::t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ src/cct_core.sv @@
`default_nettype none

module cct_core (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_cfg_we,
    input  wire [cct_pkg::IDLE_W-1:0]    i_cfg_wdata,
    input  wire                          i_fire,
    input  cct_pkg::t_item               i_item,
    output cct_pkg::t_result             o_result
);

    logic [cct_pkg::SEC_W-1:0]   r_sec,   n_sec;
    logic [cct_pkg::MIN_W-1:0]   r_min,   n_min;
    logic [cct_pkg::HOUR_W-1:0]  r_hour,  n_hour;
    logic [cct_pkg::DAY_W-1:0]   r_day,   n_day;
    logic [cct_pkg::MONTH_W-1:0] r_month, n_month;
    logic [cct_pkg::YEAR_W-1:0]  r_year,  n_year;
    logic [cct_pkg::IDLE_W-1:0]  r_idle,  n_idle;
    logic [cct_pkg::IDLE_W-1:0]  r_idle_limit;

    logic                        sec_wrap, min_wrap, hour_wrap, month_wrap;
    logic                        day_over, rolled;
    logic [cct_pkg::DAY_W:0]     day_inc;
    logic [cct_pkg::DAY_W-1:0]   month_len;
    logic [cct_pkg::IDLE_W-1:0]  idle_cap;

    always_comb begin
        sec_wrap   = (r_sec >= cct_pkg::SEC_LAST);
        min_wrap   = sec_wrap && (r_min >= cct_pkg::MIN_LAST);
        hour_wrap  = min_wrap && (r_hour >= cct_pkg::HOUR_LAST);
        month_len  = cct_pkg::f_month_len(r_month, cct_pkg::f_is_leap(r_year));
        day_inc    = {1'b0, r_day} + 1'b1;
        day_over   = (day_inc > {1'b0, month_len});
        month_wrap = (r_month >= cct_pkg::MONTH_LAST);
        idle_cap   = (r_idle_limit == cct_pkg::IDLE_MAX) ? cct_pkg::IDLE_MAX
                                                         : r_idle_limit + 1'b1;

        n_sec   = r_sec;
        n_min   = r_min;
        n_hour  = r_hour;
        n_day   = r_day;
        n_month = r_month;
        n_year  = r_year;
        n_idle  = r_idle;
        rolled  = 1'b0;

        if (i_item.command == cct_pkg::CMD_LOAD) begin
            n_sec   = i_item.load_second;
            n_min   = i_item.load_minute;
            n_hour  = i_item.load_hour;
            n_day   = i_item.load_day;
            n_month = i_item.load_month;
            n_year  = i_item.load_year;
        end else begin
            if (i_item.keys_idle) begin
                if (r_idle < idle_cap) begin
                    n_idle = r_idle + 1'b1;
                end
            end else begin
                n_idle = '0;
            end
            n_sec = sec_wrap ? '0 : r_sec + 1'b1;
            if (sec_wrap) begin
                n_min = min_wrap ? '0 : r_min + 1'b1;
            end
            if (min_wrap) begin
                n_hour = hour_wrap ? '0 : r_hour + 1'b1;
            end
            if (hour_wrap) begin
                rolled = 1'b1;
                n_day  = day_inc[cct_pkg::DAY_W-1:0];
                if (day_over) begin
                    n_day   = cct_pkg::DAY_RST;
                    n_month = month_wrap ? cct_pkg::MONTH_RST : r_month + 1'b1;
                    // year holds at the top of its range
                    if (month_wrap && (r_year < cct_pkg::YEAR_CAP)) begin
                        n_year = r_year + 1'b1;
                    end
                end
            end
        end

        o_result.second       = n_sec;
        o_result.minute       = n_min;
        o_result.hour         = n_hour;
        o_result.day          = n_day;
        o_result.month        = n_month;
        o_result.year         = n_year;
        o_result.backlight_on = (n_idle <= r_idle_limit);
        o_result.day_rollover = rolled;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec        <= '0;
            r_min        <= '0;
            r_hour       <= '0;
            r_day        <= cct_pkg::DAY_RST;
            r_month      <= cct_pkg::MONTH_RST;
            r_year       <= cct_pkg::YEAR_RST;
            r_idle       <= '0;
            r_idle_limit <= cct_pkg::IDLE_LIMIT_RST;
        end else begin
            if (i_cfg_we) begin
                r_idle_limit <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_sec   <= n_sec;
                r_min   <= n_min;
                r_hour  <= n_hour;
                r_day   <= n_day;
                r_month <= n_month;
                r_year  <= n_year;
                r_idle  <= n_idle;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/cct_out_stage.sv @@
`default_nettype none

module cct_out_stage (
    input  wire              i_clk,
    input  wire              i_rst_n,
    output logic             o_can_load,
    input  wire              i_load,
    input  cct_pkg::t_result i_result,
    output logic             o_valid,
    input  wire              i_ready,
    output cct_pkg::t_result o_result
);

    logic             r_valid;
    cct_pkg::t_result r_result;

    assign o_can_load = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_result   = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_load) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_can_load && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

`default_nettype wire

@@ src/calendar_clock_tick.sv @@
// calendar clock: each input transaction is a one-second tick or a time load,
// and each gives exactly one result transaction with the time after it, the
// backlight flag and a midnight flag
// input channel i_in_valid / o_in_ready, result channel o_out_valid / i_out_ready;
// a transaction moves on a clock edge where its valid and ready are both high
// the idle limit register is written through i_cfg_we / i_cfg_wdata, no wait
// order: an accepted transaction lands in the input register, and the calendar
// update writes the result register when that register can take it, raising
// o_out_valid; throughput: one transaction per cycle while the receiver does
// not stall; the calendar carry chain, leap test and idle counter all settle
// in the single stage between the two registers
// reset (synchronous, active low) sets 00:00:00 on 2000-01-01, clears the idle
// count, loads idle limit 4 and empties both registers
// when the receiver stalls, the result register holds, the input register
// fills, and o_in_ready drops; nothing is dropped or repeated
`default_nettype none

module calendar_clock_tick (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [cct_pkg::IDLE_W-1:0]        i_cfg_wdata,
    input  wire                              i_in_valid,
    output logic                             o_in_ready,
    input  wire                              i_command,
    input  wire [cct_pkg::SEC_W-1:0]         i_load_second,
    input  wire [cct_pkg::MIN_W-1:0]         i_load_minute,
    input  wire [cct_pkg::HOUR_W-1:0]        i_load_hour,
    input  wire [cct_pkg::DAY_W-1:0]         i_load_day,
    input  wire [cct_pkg::MONTH_W-1:0]       i_load_month,
    input  wire [cct_pkg::YEAR_W-1:0]        i_load_year,
    input  wire                              i_keys_idle,
    output logic                             o_out_valid,
    input  wire                              i_out_ready,
    output logic [cct_pkg::SEC_W-1:0]        o_second,
    output logic [cct_pkg::MIN_W-1:0]        o_minute,
    output logic [cct_pkg::HOUR_W-1:0]       o_hour,
    output logic [cct_pkg::DAY_W-1:0]        o_day,
    output logic [cct_pkg::MONTH_W-1:0]      o_month,
    output logic [cct_pkg::YEAR_W-1:0]       o_year,
    output logic                             o_backlight_on,
    output logic                             o_day_rollover
);

    cct_pkg::t_item   in_item;
    cct_pkg::t_item   stage_item;
    cct_pkg::t_result next_result;
    cct_pkg::t_result out_result;
    logic             stage_valid;
    logic             can_load;
    logic             fire;

    assign in_item.command     = i_command;
    assign in_item.load_second = i_load_second;
    assign in_item.load_minute = i_load_minute;
    assign in_item.load_hour   = i_load_hour;
    assign in_item.load_day    = i_load_day;
    assign in_item.load_month  = i_load_month;
    assign in_item.load_year   = i_load_year;
    assign in_item.keys_idle   = i_keys_idle;

    // staged transaction is processed when the result register can take it
    assign fire = stage_valid && can_load;

    cct_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (stage_valid),
        .o_item  (stage_item),
        .i_take  (can_load)
    );

    cct_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (stage_item),
        .o_result    (next_result)
    );

    cct_out_stage u_out_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_can_load (can_load),
        .i_load     (stage_valid),
        .i_result   (next_result),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_result   (out_result)
    );

    assign o_second       = out_result.second;
    assign o_minute       = out_result.minute;
    assign o_hour         = out_result.hour;
    assign o_day          = out_result.day;
    assign o_month        = out_result.month;
    assign o_year         = out_result.year;
    assign o_backlight_on = out_result.backlight_on;
    assign o_day_rollover = out_result.day_rollover;

endmodule

`default_nettype wire
